// ===== rtl/valve_actuator_drive_fsm_macros.svh =====
// Assertion macros for the valve actuator drive block.
// Needs nothing else; define NO_ASSERTIONS to compile the checks out.
`ifndef VALVE_ACTUATOR_DRIVE_FSM_MACROS_SVH
`define VALVE_ACTUATOR_DRIVE_FSM_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define VAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vad assertion failed");
// Next-cycle implication, disabled during reset
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vad assertion failed");
`else
`define VAD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/vad_pkg.sv =====
// Shared types and constants for the valve actuator drive block.
// No dependencies; used by the top level.
`default_nettype none

package vad_pkg;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] CfgTorqueSetpoint = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCloseByLimit   = 2'd1;

  // Thresholds in tenths of percent and 100 us ticks
  localparam logic [9:0]  PosOpen      = 10'd995;
  localparam logic [9:0]  PosClosed    = 10'd5;
  localparam logic [9:0]  PosNear      = 10'd50;
  localparam logic [9:0]  TReversal    = 10'd800;
  localparam logic [13:0] THammer      = 14'd140;
  localparam logic [15:0] TJam         = 16'd4000;
  localparam logic [11:0] TqJam        = 12'd1500;
  localparam logic [11:0] TqSeatTrip   = 12'd1100;
  localparam logic [11:0] TqLimMin     = 12'd10;
  localparam logic [11:0] TqLimDefault = 12'd1000;
  localparam logic [11:0] TqSetReset   = 12'd1000;

  // Raw command codes on the input field
  localparam logic [1:0] CmdRawStop = 2'b00;
  localparam logic [1:0] CmdRawOpen = 2'b01;
  localparam logic [1:0] ModeOff    = 2'd2;

  typedef enum logic [1:0] {
    CmdStop  = 2'd0,
    CmdOpen  = 2'd1,
    CmdClose = 2'd2
  } vad_cmd_e;

  typedef enum logic [2:0] {
    StStop    = 3'd0,
    StOpening = 3'd1,
    StClosing = 3'd2,
    StOpened  = 3'd3,
    StClosed  = 3'd4,
    StFault   = 3'd5
  } vad_state_e;

  typedef enum logic [2:0] {
    FcOk         = 3'd0,
    FcWarn       = 3'd1,
    FcPhase      = 3'd2,
    FcTherm      = 3'd3,
    FcPos        = 3'd4,
    FcJam        = 3'd5,
    FcOvertorque = 3'd6
  } vad_fault_e;

endpackage

`default_nettype wire

// ===== rtl/vad_in_if.sv =====
// Input channel of the valve actuator drive block: one control tick per transfer.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface vad_in_if;
  logic               valid;
  logic               ready;
  logic signed [1:0]  cmd;
  logic        [1:0]  mode;
  logic               hw_good;
  logic               thm_good;
  logic               phs_good;
  logic               pos_ok;
  logic               tq_valid;
  logic        [9:0]  position;
  logic        [11:0] torque;
  logic        [13:0] elapsed;
  logic               clear_latch;

  modport source (
    output valid, cmd, mode, hw_good, thm_good, phs_good, pos_ok, tq_valid,
           position, torque, elapsed, clear_latch,
    input  ready
  );
  modport sink (
    input  valid, cmd, mode, hw_good, thm_good, phs_good, pos_ok, tq_valid,
           position, torque, elapsed, clear_latch,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/vad_out_if.sv =====
// Result channel of the valve actuator drive block: coil drive and status per tick.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface vad_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] drive_state;
  logic [2:0] flt_code;
  logic       open_coil;
  logic       close_coil;
  logic       running;
  logic       at_open;
  logic       at_closed;
  logic       alarm_relay;

  modport source (
    output valid, drive_state, flt_code, open_coil, close_coil, running,
           at_open, at_closed, alarm_relay,
    input  ready
  );
  modport sink (
    input  valid, drive_state, flt_code, open_coil, close_coil, running,
           at_open, at_closed, alarm_relay,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/valve_actuator_drive_fsm.sv =====
// Valve actuator drive: coil control, timers and fault latch, one tick per transfer.
// Depends on vad_pkg, vad_in_if, vad_out_if and valve_actuator_drive_fsm_macros.svh.
//
// Usage:
//   Each input transfer on in_i is one control tick (command, mode, health
//   flags, position, torque, elapsed time). Each tick yields exactly one
//   result on out_o with the contactor coil drive and status.
//   The result is registered and valid in the cycle after the input
//   transfer; the whole tick is evaluated in the accept cycle and lands in the
//   result register, while timers, latch and last command update at the same edge.
//   Throughput: one tick per cycle. in_i.ready is high while the result
//   register is empty or being drained, so a stalled receiver holds the
//   current result and stops input only for as long as it stalls.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 torque setpoint,
//   1 close-by-limit) with cfg_data_i; other indexes are ignored. Write only
//   while no tick is pending.
//   Reset: clears all timers, the fault latch, the last command (stop),
//   the reported state (stop) and fault (ok), drops out_o.valid and restores
//   the setpoint to 1000 and torque seating.
`default_nettype none
`include "valve_actuator_drive_fsm_macros.svh"

module valve_actuator_drive_fsm (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [vad_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [vad_pkg::CfgDataW-1:0] cfg_data_i,
  vad_in_if.sink                      in_i,
  vad_out_if.source                   out_o
);

  // Configuration registers
  logic [11:0] tq_set_q;
  logic        close_lim_q;

  // Tick state
  logic [9:0]           rev_q, rev_d;
  logic [13:0]          ham_q, ham_d;
  logic [15:0]          jam_q, jam_d;
  vad_pkg::vad_cmd_e    prev_q, prev_d;
  logic                 latch_q, latch_d;
  vad_pkg::vad_state_e  rst_q, rst_d;
  vad_pkg::vad_fault_e  rfc_q, rfc_d;

  // Result register
  logic       out_valid_q;
  logic [2:0] st_q, fc_q;
  logic       oc_q, cc_q, aopen_q, aclosed_q, relay_q;
  logic       oc_d, cc_d, relay_d, aclosed_d;

  // Combinational helpers
  vad_pkg::vad_cmd_e    cmd;
  vad_pkg::vad_state_e  st;
  vad_pkg::vad_fault_e  fc;
  logic                 in_xfer;
  logic                 health_bad;
  logic                 latch_in;
  logic                 rev_set;
  logic [9:0]           rev_cur;
  logic [11:0]          tlim;
  logic [14:0]          ham_sum;
  logic [13:0]          ham_new;
  logic [16:0]          jam_sum;
  logic [15:0]          jam_new;
  logic [18:0]          tq_x100, lim_x105;
  logic                 bypass, over_open, t_hit, lim_hit;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Decode the command; mode off forces stop
  always_comb begin
    unique case (in_i.cmd)
      vad_pkg::CmdRawStop: cmd = vad_pkg::CmdStop;
      vad_pkg::CmdRawOpen: cmd = vad_pkg::CmdOpen;
      default:             cmd = vad_pkg::CmdClose;
    endcase
    if (in_i.mode == vad_pkg::ModeOff) cmd = vad_pkg::CmdStop;
  end

  assign health_bad = !in_i.hw_good || !in_i.thm_good || !in_i.phs_good || !in_i.pos_ok;
  assign latch_in   = latch_q && !in_i.clear_latch;
  assign rev_set    = (prev_q != vad_pkg::CmdStop) && (cmd != vad_pkg::CmdStop) &&
                      (cmd != prev_q);
  assign rev_cur    = rev_set ? vad_pkg::TReversal : rev_q;
  assign tlim       = (tq_set_q > vad_pkg::TqLimMin) ? tq_set_q : vad_pkg::TqLimDefault;

  // Saturating timer sums
  assign ham_sum = {1'b0, ham_q} + {1'b0, in_i.elapsed};
  assign ham_new = (ham_q < vad_pkg::THammer) ?
                   (ham_sum[14] ? 14'h3FFF : ham_sum[13:0]) : ham_q;
  assign jam_sum = {1'b0, jam_q} + {3'b000, in_i.elapsed};
  assign jam_new = jam_sum[16] ? 16'hFFFF : jam_sum[15:0];

  // Exact torque compare: 100*torque against 105*limit
  assign tq_x100   = 19'(in_i.torque) * 19'd100;
  assign lim_x105  = 19'(tlim) * 19'd105;
  assign bypass    = (cmd == vad_pkg::CmdOpen) && (in_i.position < vad_pkg::PosNear);
  assign over_open = !bypass && in_i.tq_valid && (tq_x100 > lim_x105) &&
                     (ham_new >= vad_pkg::THammer);
  assign t_hit     = in_i.tq_valid && (in_i.torque >= tlim);
  assign lim_hit   = in_i.position <= vad_pkg::PosClosed;

  // Evaluate one tick
  always_comb begin
    rev_d     = rev_q;
    ham_d     = ham_q;
    jam_d     = jam_q;
    prev_d    = prev_q;
    latch_d   = latch_in;
    rst_d     = rst_q;
    rfc_d     = rfc_q;
    oc_d      = 1'b0;
    cc_d      = 1'b0;
    relay_d   = 1'b0;
    aclosed_d = lim_hit;
    st        = vad_pkg::StStop;
    fc        = vad_pkg::FcOk;
    priority if (health_bad) begin
      // Health fault: latch, coils off, relay on
      rst_d   = vad_pkg::StFault;
      latch_d = 1'b1;
      relay_d = 1'b1;
      priority if (!in_i.phs_good) rfc_d = vad_pkg::FcPhase;
      else if (!in_i.thm_good)     rfc_d = vad_pkg::FcTherm;
      else if (!in_i.pos_ok)       rfc_d = vad_pkg::FcPos;
      else                         rfc_d = vad_pkg::FcJam;
    end else if (latch_in) begin
      // Latched: hold until a stop command
      relay_d = 1'b1;
      if (cmd == vad_pkg::CmdStop) begin
        latch_d = 1'b0;
        rst_d   = vad_pkg::StStop;
        rfc_d   = vad_pkg::FcOk;
        relay_d = 1'b0;
      end
    end else if (rev_cur != 10'd0) begin
      // Reversal dead time: both coils off, fault code kept
      prev_d = cmd;
      rev_d  = ({4'b0000, rev_cur} <= in_i.elapsed) ? 10'd0 : rev_cur - in_i.elapsed[9:0];
      rst_d  = vad_pkg::StStop;
    end else begin
      prev_d = cmd;
      unique case (cmd)
        vad_pkg::CmdOpen: begin
          if (in_i.position >= vad_pkg::PosOpen) begin
            st = vad_pkg::StOpened;
          end else begin
            ham_d = ham_new;
            priority if (over_open) begin
              st      = vad_pkg::StFault;
              fc      = vad_pkg::FcOvertorque;
              latch_d = 1'b1;
            end else if (bypass && in_i.tq_valid && (in_i.torque > vad_pkg::TqJam)) begin
              jam_d = jam_new;
              if (jam_new > vad_pkg::TJam) begin
                st      = vad_pkg::StFault;
                fc      = vad_pkg::FcJam;
                latch_d = 1'b1;
              end else begin
                oc_d = 1'b1;
                st   = vad_pkg::StOpening;
              end
            end else begin
              jam_d = 16'd0;
              oc_d  = 1'b1;
              st    = vad_pkg::StOpening;
            end
          end
        end
        vad_pkg::CmdClose: begin
          ham_d = 14'd0;
          priority if (close_lim_q) begin
            priority if (lim_hit) begin
              st = vad_pkg::StClosed;
            end else if (t_hit && (in_i.torque >= vad_pkg::TqSeatTrip)) begin
              st      = vad_pkg::StFault;
              fc      = vad_pkg::FcOvertorque;
              latch_d = 1'b1;
            end else begin
              cc_d = 1'b1;
              st   = vad_pkg::StClosing;
            end
          end else if (t_hit || lim_hit) begin
            st = vad_pkg::StClosed;
          end else begin
            cc_d = 1'b1;
            st   = vad_pkg::StClosing;
          end
        end
        default: begin
          ham_d = 14'd0;
          jam_d = 16'd0;
          priority if (in_i.position >= vad_pkg::PosOpen) st = vad_pkg::StOpened;
          else if (lim_hit)                               st = vad_pkg::StClosed;
          else                                            st = vad_pkg::StStop;
        end
      endcase
      rst_d     = st;
      relay_d   = (st == vad_pkg::StFault);
      aclosed_d = lim_hit || (st == vad_pkg::StClosed);
      if (st == vad_pkg::StFault)  rfc_d = fc;
      else if (in_i.tq_valid)      rfc_d = vad_pkg::FcOk;
      else                         rfc_d = vad_pkg::FcWarn;
    end
  end

  // Hold configuration; ignore indexes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tq_set_q    <= vad_pkg::TqSetReset;
      close_lim_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vad_pkg::CfgTorqueSetpoint: tq_set_q    <= cfg_data_i[11:0];
        vad_pkg::CfgCloseByLimit:   close_lim_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance tick state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q   <= '0;
      ham_q   <= '0;
      jam_q   <= '0;
      prev_q  <= vad_pkg::CmdStop;
      latch_q <= 1'b0;
      rst_q   <= vad_pkg::StStop;
      rfc_q   <= vad_pkg::FcOk;
    end else if (in_xfer) begin
      rev_q   <= rev_d;
      ham_q   <= ham_d;
      jam_q   <= jam_d;
      prev_q  <= prev_d;
      latch_q <= latch_d;
      rst_q   <= rst_d;
      rfc_q   <= rfc_d;
    end
  end

  // Result valid: set on input transfer, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      st_q      <= rst_d;
      fc_q      <= rfc_d;
      oc_q      <= oc_d;
      cc_q      <= cc_d;
      aopen_q   <= in_i.position >= vad_pkg::PosOpen;
      aclosed_q <= aclosed_d;
      relay_q   <= relay_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_state = st_q;
  assign out_o.flt_code    = fc_q;
  assign out_o.open_coil   = oc_q;
  assign out_o.close_coil  = cc_q;
  assign out_o.running     = oc_q || cc_q;
  assign out_o.at_open     = aopen_q;
  assign out_o.at_closed   = aclosed_q;
  assign out_o.alarm_relay = relay_q;

  // Checks
  `VAD_ASSERT_NOW(a_coils_exclusive, clk_i, rst_ni, out_valid_q, !(oc_q && cc_q))
  `VAD_ASSERT_NOW(a_relay_no_drive, clk_i, rst_ni, out_valid_q && relay_q, !(oc_q || cc_q))
  `VAD_ASSERT_NEXT(a_latch_coils_off, clk_i, rst_ni, in_xfer && latch_in, !out_o.running)

endmodule

`default_nettype wire
